/* rtl/dat_pkg.sv */
// Package for the device address table: sizes, command and status codes,
// and the control and status structs shared by controller and datapath.
// No dependencies.
package dat_pkg;

  localparam int TABLE_ENTRIES = 24;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 48;
  localparam int IDENT_W = 64;
  localparam int COUNT_W = 5;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_GET    = 2'd2;

  // status codes
  localparam logic [1:0] ST_SUCCESS   = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // one table entry as held in the memory
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [IDENT_W-1:0] ident_high;
    logic [IDENT_W-1:0] ident_low;
  } dat_entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // latch the incoming word, restart the scan
    logic issue;   // read the slot at the scan index, advance the index
    logic commit;  // update the table and load the result register
  } dat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;  // the scan index is on the last slot
    logic out_free;    // the result register can take a new word
  } dat_stat_t;

endpackage

/* rtl/dat_ctrl.sv */
// Controller for the device address table: sequences accept, slot scan,
// drain of the last read and commit of the result.
// Depends on dat_pkg.
module dat_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dat_pkg::dat_stat_t stat,
  output dat_pkg::dat_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.start = in_valid;
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.last_issue) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.commit = stat.out_free;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  // a word is only taken when the controller starts on it
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> cmd.start)
    else $error("word accepted without start");

  // the scan always ends in drain then finish
  a_drain_after_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && stat.last_issue) |=> (state == S_DRAIN))
    else $error("scan did not drain");

  // commit never overwrites a stalled result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit with result register busy");
`endif

endmodule

/* rtl/dat_datapath.sv */
// Datapath for the device address table: entry memory, valid bits, entry
// count, scan evaluation and the result register.
// Depends on dat_pkg.
module dat_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dat_pkg::dat_cmd_t                 cmd,
  output dat_pkg::dat_stat_t                stat,
  input  logic [1:0]                        command,
  input  logic [dat_pkg::ADDR_W-1:0]        device_address,
  input  logic [dat_pkg::IDENT_W-1:0]       ident_high,
  input  logic [dat_pkg::IDENT_W-1:0]       ident_low,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        status,
  output logic [dat_pkg::ADDR_W-1:0]        found_address,
  output logic [dat_pkg::IDENT_W-1:0]       found_ident_high,
  output logic [dat_pkg::IDENT_W-1:0]       found_ident_low,
  output logic [dat_pkg::COUNT_W-1:0]       entry_count
);

  // table storage
  dat_pkg::dat_entry_t mem [dat_pkg::TABLE_ENTRIES];
  logic [dat_pkg::TABLE_ENTRIES-1:0] valid;
  logic [dat_pkg::CNT_W-1:0]         count;
  logic [dat_pkg::CNT_W-1:0]         count_next;

  // current word
  logic [1:0]                  item_cmd;
  dat_pkg::dat_entry_t         item;

  // scan state
  logic [dat_pkg::IDX_W-1:0]   idx;
  logic                        pend;
  logic [dat_pkg::IDX_W-1:0]   rd_idx;
  dat_pkg::dat_entry_t         rd_entry;
  logic                        rd_v;

  // scan findings
  logic                        hit;
  logic [dat_pkg::IDX_W-1:0]   hit_idx;
  logic                        free;
  logic [dat_pkg::IDX_W-1:0]   free_idx;
  logic                        first;
  logic                        first_take;
  dat_pkg::dat_entry_t         first_entry;

  // result decode
  logic [1:0]                  res_status;
  dat_pkg::dat_entry_t         res_entry;
  logic                        do_write;
  logic                        do_clear;

  assign stat.last_issue = (idx == dat_pkg::LAST_IDX);
  assign stat.out_free   = !out_valid || !out_stall;

  assign first_take = pend && rd_v && !first;

  // outcome of the finished scan
  always_comb begin
    res_status = dat_pkg::ST_NOT_FOUND;
    res_entry  = '0;
    do_write   = 1'b0;
    do_clear   = 1'b0;
    count_next = count;
    case (item_cmd)
      dat_pkg::CMD_ADD: begin
        if (hit) begin
          res_status = dat_pkg::ST_PRESENT;
        end else if (free) begin
          res_status = dat_pkg::ST_SUCCESS;
          do_write   = 1'b1;
          count_next = count + 1'b1;
        end else begin
          res_status = dat_pkg::ST_FULL;
        end
      end
      dat_pkg::CMD_REMOVE: begin
        if (hit) begin
          res_status = dat_pkg::ST_SUCCESS;
          do_clear   = 1'b1;
          if (count != '0) count_next = count - 1'b1;
        end
      end
      dat_pkg::CMD_GET: begin
        if (first) begin
          res_status = dat_pkg::ST_SUCCESS;
          res_entry  = first_entry;
        end
      end
      default: begin
        res_status = dat_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) mem[free_idx] <= item;
    rd_entry <= mem[idx];
  end

  // word capture, scan index and read pipeline
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      item_cmd        <= command;
      item.addr       <= device_address;
      item.ident_high <= ident_high;
      item.ident_low  <= ident_low;
    end
    rd_idx <= idx;
    rd_v   <= valid[idx];
    if (first_take) first_entry <= rd_entry;
  end

  // control flags of the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
      free  <= 1'b0;
      first <= 1'b0;
      hit_idx  <= '0;
      free_idx <= '0;
    end else begin
      pend <= cmd.issue;
      if (cmd.start) begin
        idx   <= '0;
        hit   <= 1'b0;
        free  <= 1'b0;
        first <= 1'b0;
      end else begin
        if (cmd.issue && !stat.last_issue) idx <= idx + 1'b1;
        if (pend && rd_v && !hit && (rd_entry.addr == item.addr)) begin
          hit     <= 1'b1;
          hit_idx <= rd_idx;
        end
        if (pend && !rd_v && !free) begin
          free     <= 1'b1;
          free_idx <= rd_idx;
        end
        if (first_take) first <= 1'b1;
      end
    end
  end

  // valid bits and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      if (do_write) valid[free_idx] <= 1'b1;
      if (do_clear) valid[hit_idx]  <= 1'b0;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.commit) begin
      status           <= res_status;
      found_address    <= res_entry.addr;
      found_ident_high <= res_entry.ident_high;
      found_ident_low  <= res_entry.ident_low;
      entry_count      <= dat_pkg::COUNT_W'(count_next);
    end
  end

`ifndef SYNTH
  // the count always tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    count == dat_pkg::CNT_W'($countones(valid)))
    else $error("entry count out of step with valid bits");

  // a match found by the scan still names a valid slot at commit
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && hit) |-> valid[hit_idx])
    else $error("matched slot not valid at commit");

  // an add only lands in a free slot
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_write) |-> !valid[free_idx])
    else $error("add overwrites a valid slot");
`endif

endmodule

/* rtl/device_address_table_unit.sv */
// Top level of the device address table: joins the controller and datapath.
// Depends on dat_pkg, dat_ctrl and dat_datapath.
//
// Input channel: command, device_address, ident_high, ident_low with
// in_valid/in_stall; a word is taken on an edge with in_valid high and
// in_stall low. Output channel: status, found_address, found_ident_high,
// found_ident_low, entry_count with out_valid/out_stall.
// Each command scans every slot of the table through one memory read port,
// one slot per cycle, then passes through a drain state and a commit state.
// The result is registered at commit, and a new word is taken the cycle
// after commit, so no word is taken while another is still in progress.
// The result sits in an output register; the next word can be taken and
// scanned while it waits. If the receiver still stalls when the next commit
// is due, the block holds in its commit cycle until the register frees.
// Reset (rst, synchronous) clears every valid mark, the entry count and both
// channels' control state; no clearing pass is needed.
module device_address_table_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic [dat_pkg::ADDR_W-1:0]  device_address,
  input  logic [dat_pkg::IDENT_W-1:0] ident_high,
  input  logic [dat_pkg::IDENT_W-1:0] ident_low,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  status,
  output logic [dat_pkg::ADDR_W-1:0]  found_address,
  output logic [dat_pkg::IDENT_W-1:0] found_ident_high,
  output logic [dat_pkg::IDENT_W-1:0] found_ident_low,
  output logic [dat_pkg::COUNT_W-1:0] entry_count
);

  dat_pkg::dat_cmd_t  cmd;
  dat_pkg::dat_stat_t stat;

  // sequencing
  dat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, scan and result
  dat_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .command          (command),
    .device_address   (device_address),
    .ident_high       (ident_high),
    .ident_low        (ident_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .found_address    (found_address),
    .found_ident_high (found_ident_high),
    .found_ident_low  (found_ident_low),
    .entry_count      (entry_count)
  );

endmodule

/* test/tb_device_address_table_unit.sv */
// Testbench for device_address_table_unit: directed and random add, remove and
// get-first traffic, checked word by word against a predictor of the table.
// Depends on dat_pkg and the RTL of device_address_table_unit.
module tb_device_address_table_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W        = dat_pkg::ADDR_W;
  localparam int IDENT_W       = dat_pkg::IDENT_W;
  localparam int COUNT_W       = dat_pkg::COUNT_W;
  localparam int TABLE_ENTRIES = dat_pkg::TABLE_ENTRIES;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused command code
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 400;

  // one expected result word
  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  addr;
    logic [IDENT_W-1:0] ident_high;
    logic [IDENT_W-1:0] ident_low;
    logic [COUNT_W-1:0] count;
  } table_reply_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           command;
  logic [ADDR_W-1:0]    device_address;
  logic [IDENT_W-1:0]   ident_high;
  logic [IDENT_W-1:0]   ident_low;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    found_address;
  logic [IDENT_W-1:0]   found_ident_high;
  logic [IDENT_W-1:0]   found_ident_low;
  logic [COUNT_W-1:0]   entry_count;

  // predicted table contents
  logic               tbl_live [TABLE_ENTRIES];
  logic [ADDR_W-1:0]  tbl_addr [TABLE_ENTRIES];
  logic [IDENT_W-1:0] tbl_hi   [TABLE_ENTRIES];
  logic [IDENT_W-1:0] tbl_lo   [TABLE_ENTRIES];
  int                 live_count;

  table_reply_t       pending_replies[$];
  logic [ADDR_W-1:0]  addr_pool [16];
  int                 error_count;
  int                 cycle_count;
  int                 send_idle_pct;
  int                 stall_pct;
  int                 hold_req;

  device_address_table_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .device_address   (device_address),
    .ident_high       (ident_high),
    .ident_low        (ident_low),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .found_address    (found_address),
    .found_ident_high (found_ident_high),
    .found_ident_low  (found_ident_low),
    .entry_count      (entry_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [IDENT_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // lowest slot whose live mark equals want_live, -1 if none
  function automatic int lowest_slot(logic want_live);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (tbl_live[i] == want_live) return i;
    return -1;
  endfunction

  // address of a random live slot, or a fresh one if the table is empty
  function automatic logic [ADDR_W-1:0] pick_live_address();
    int idx;
    if (live_count == 0) return rand48();
    idx = $urandom_range(TABLE_ENTRIES - 1);
    while (!tbl_live[idx]) idx = (idx + 1) % TABLE_ENTRIES;
    return tbl_addr[idx];
  endfunction

  // apply one command to the predicted table and work out its reply
  function automatic table_reply_t predict_step(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                                                logic [IDENT_W-1:0] hi,
                                                logic [IDENT_W-1:0] lo);
    table_reply_t r;
    int hit;
    int slot;
    r = '0;
    r.status = dat_pkg::ST_NOT_FOUND;
    hit = -1;
    // only live slots can match
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (hit < 0 && tbl_live[i] && tbl_addr[i] == addr) hit = i;
    case (cmd)
      dat_pkg::CMD_ADD: begin
        if (hit >= 0) begin
          r.status = dat_pkg::ST_PRESENT;
        end else begin
          slot = lowest_slot(1'b0);
          if (slot >= 0) begin
            tbl_live[slot] = 1'b1;
            tbl_addr[slot] = addr;
            tbl_hi[slot]   = hi;
            tbl_lo[slot]   = lo;
            live_count++;
            r.status = dat_pkg::ST_SUCCESS;
          end else begin
            r.status = dat_pkg::ST_FULL;
          end
        end
      end
      dat_pkg::CMD_REMOVE: begin
        if (hit >= 0) begin
          tbl_live[hit] = 1'b0;
          if (live_count > 0) live_count--;
          r.status = dat_pkg::ST_SUCCESS;
        end
      end
      dat_pkg::CMD_GET: begin
        slot = lowest_slot(1'b1);
        if (slot >= 0) begin
          r.addr       = tbl_addr[slot];
          r.ident_high = tbl_hi[slot];
          r.ident_low  = tbl_lo[slot];
          r.status     = dat_pkg::ST_SUCCESS;
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(live_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [IDENT_W-1:0] got,
                                 logic [IDENT_W-1:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // offer one word, wait for it to be taken, then log its expected reply
  task automatic send_word(logic [1:0] cmd, logic [ADDR_W-1:0] addr,
                           logic [IDENT_W-1:0] hi, logic [IDENT_W-1:0] lo);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 60) : 0;
    @(negedge clk);
    while (gap > 0) begin
      in_valid <= 1'b0;
      gap--;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    command        <= cmd;
    device_address <= addr;
    ident_high     <= hi;
    ident_low      <= lo;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(predict_step(cmd, addr, hi, lo));
  endtask

  // one random word; add and remove addresses mostly from the live table or a small pool
  task automatic random_word(int add_pct, int rem_pct);
    int r;
    logic [1:0] cmd;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(99);
    if (r < add_pct) cmd = dat_pkg::CMD_ADD;
    else if (r < add_pct + rem_pct) cmd = dat_pkg::CMD_REMOVE;
    else if (r < 97) cmd = dat_pkg::CMD_GET;
    else cmd = CMD_SPARE;
    r = $urandom_range(99);
    if (cmd == dat_pkg::CMD_ADD)
      addr = (r < 15) ? pick_live_address() : (r < 75) ? addr_pool[$urandom_range(15)] :
             rand48();
    else if (cmd == dat_pkg::CMD_REMOVE)
      addr = (r < 65) ? pick_live_address() : (r < 90) ? addr_pool[$urandom_range(15)] :
             rand48();
    else
      addr = rand48();
    send_word(cmd, addr, rand64(), rand64());
  endtask

  // result checker
  always @(posedge clk) begin
    table_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected word, status", IDENT_W'(status), '0);
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status)
          report_mismatch("status", IDENT_W'(status), IDENT_W'(want.status));
        if (found_address !== want.addr)
          report_mismatch("found_address", IDENT_W'(found_address), IDENT_W'(want.addr));
        if (found_ident_high !== want.ident_high)
          report_mismatch("found_ident_high", found_ident_high, want.ident_high);
        if (found_ident_low !== want.ident_low)
          report_mismatch("found_ident_low", found_ident_low, want.ident_low);
        if (entry_count !== want.count)
          report_mismatch("entry_count", IDENT_W'(entry_count), IDENT_W'(want.count));
      end
    end
  end

  // receiver: random stalls cycle by cycle, or one long hold when asked
  initial begin
    int burst;
    int hold_seen;
    burst     = 0;
    hold_seen = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        burst = HOLD_CYCLES;
      end else if (burst == 0 && $urandom_range(99) < stall_pct) begin
        burst = 1;
      end
      if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // extremes, each command, empty table, stale addresses, unused command
  task automatic test_directed();
    logic [ADDR_W-1:0] a_max;
    logic [ADDR_W-1:0] a_alt;
    logic [ADDR_W-1:0] a_inv;
    a_max = '1;
    a_alt = {(ADDR_W/2){2'b10}};
    a_inv = ~a_alt;
    send_word(dat_pkg::CMD_GET, '0, '0, '0);
    send_word(dat_pkg::CMD_REMOVE, '0, '0, '0);
    send_word(CMD_SPARE, '0, '0, '0);
    send_word(dat_pkg::CMD_ADD, '0, '0, '0);
    send_word(dat_pkg::CMD_ADD, a_max, '1, '1);
    send_word(dat_pkg::CMD_ADD, '0, '1, '1);          // already present
    send_word(dat_pkg::CMD_ADD, a_alt, {32{2'b01}}, {32{2'b10}});
    send_word(dat_pkg::CMD_GET, a_max, '1, '1);
    send_word(CMD_SPARE, a_max, '1, '1);
    send_word(dat_pkg::CMD_REMOVE, '0, '1, '1);
    send_word(dat_pkg::CMD_REMOVE, '0, '0, '0);       // cleared slot must not match
    send_word(dat_pkg::CMD_GET, '0, '0, '0);
    send_word(dat_pkg::CMD_ADD, a_inv, {32{2'b10}}, {32{2'b01}});  // fills the hole
    send_word(dat_pkg::CMD_GET, '0, '0, '0);
    send_word(dat_pkg::CMD_REMOVE, a_max, '0, '0);
    send_word(dat_pkg::CMD_REMOVE, a_inv, '0, '0);
    send_word(dat_pkg::CMD_REMOVE, a_alt, '0, '0);
    send_word(dat_pkg::CMD_GET, '0, '0, '0);
  endtask

  // fill to full, refuse, punch a hole, refill it, then empty the table
  task automatic test_fill_and_drain();
    logic [ADDR_W-1:0] fill_addr [TABLE_ENTRIES];
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      fill_addr[i] = rand48();
      send_word(dat_pkg::CMD_ADD, fill_addr[i], rand64(), rand64());
    end
    send_word(dat_pkg::CMD_ADD, rand48(), rand64(), rand64());
    send_word(dat_pkg::CMD_ADD, fill_addr[5], rand64(), rand64());
    send_word(dat_pkg::CMD_REMOVE, fill_addr[TABLE_ENTRIES/2], '0, '0);
    send_word(dat_pkg::CMD_ADD, rand48(), rand64(), rand64());
    send_word(dat_pkg::CMD_REMOVE, fill_addr[0], '0, '0);
    send_word(dat_pkg::CMD_GET, '0, '0, '0);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      send_word(dat_pkg::CMD_REMOVE, pick_live_address(), rand64(), rand64());
    send_word(dat_pkg::CMD_GET, '0, '0, '0);
  endtask

  // random traffic in filling, mixed and draining stretches, per idling mode
  task automatic test_idle_phases(int words_per_phase);
    int idle_mode [4][2] = '{'{0, 0}, '{86, 0}, '{0, 86}, '{10, 10}};
    int mode;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_mode[p][0];
      stall_pct     = idle_mode[p][1];
      for (int i = 0; i < words_per_phase; i++) begin
        mode = (i / 40) % 3;
        if (mode == 0) random_word(75, 10);
        else if (mode == 1) random_word(35, 35);
        else random_word(15, 70);
      end
    end
  endtask

  // long receiver hold while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req++;
    for (int i = 0; i < 10; i++) random_word(50, 30);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = dat_pkg::CMD_ADD;
    device_address = '0;
    ident_high     = '0;
    ident_low      = '0;
    hold_req       = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    error_count    = 0;
    live_count     = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_live[i] = 1'b0;
      tbl_addr[i] = '0;
      tbl_hi[i]   = '0;
      tbl_lo[i]   = '0;
    end
    for (int i = 0; i < 16; i++) addr_pool[i] = rand48();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_fill_and_drain();
    test_idle_phases(270);
    test_output_backpressure();

    // stop offering, let every result drain
    @(negedge clk);
    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dat_pkg.sv
rtl/dat_ctrl.sv
rtl/dat_datapath.sv
rtl/device_address_table_unit.sv
test/tb_device_address_table_unit.sv
